FILE: design/hmtq_pkg.sv
// Shared types and constants for the heightmap triangle height query block.
// Used by the controller, the datapath and the top level. No dependencies.
`default_nettype none

package hmtq_pkg;

  // Request kinds carried on req_type.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_TILE_SIZE = 2'd0;
  localparam logic [1:0] CFG_TILE_COL  = 2'd1;
  localparam logic [1:0] CFG_TILE_ROW  = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] TILE_SIZE_RST = 16'd256;

  // Saturation limits of a signed Q.8 height.
  localparam logic signed [23:0] H_MAX = 24'sh7FFFFF;
  localparam logic signed [23:0] H_MIN = -24'sh800000;

  // Q.16 one, used for the triangle test and upper triangle weights.
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // Controller states, one-hot.
  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_ORG  = 11'b000_0000_0010,
    S_CHK  = 11'b000_0000_0100,
    S_NMUL = 11'b000_0000_1000,
    S_DIV  = 11'b000_0001_0000,
    S_RD   = 11'b000_0010_0000,
    S_SEL  = 11'b000_0100_0000,
    S_M1   = 11'b000_1000_0000,
    S_M2   = 11'b001_0000_0000,
    S_M3   = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_en;
    logic load_pos;
    logic axis;
    logic org;
    logic chk;
    logic nmul;
    logic div;
    logic rd;
    logic sel;
    logic m1;
    logic m2;
    logic m3;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic outside;
    logic div_last;
    logic rd_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: design/hmtq_ctrl.sv
// Controller state machine of the height query block.
// Depends on hmtq_pkg for the state, command and status types.
`default_nettype none

module hmtq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            req_type,
  output logic            in_stall,
  output hmtq_pkg::cmd_t  cmd,
  input  hmtq_pkg::sts_t  sts
);
  import hmtq_pkg::*;

  state_t state, state_next;
  logic   axis, axis_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Next state and axis selection.
  always_comb begin
    state_next = state;
    axis_next  = axis;
    case (state)
      S_IDLE: begin
        if (accept && req_type == REQ_QUERY) begin
          state_next = S_ORG;
          axis_next  = 1'b0;
        end
      end
      S_ORG:  state_next = S_CHK;
      S_CHK:  state_next = sts.outside ? S_OUT : S_NMUL;
      S_NMUL: state_next = S_DIV;
      S_DIV: begin
        if (sts.div_last) begin
          if (!axis) begin
            axis_next  = 1'b1;
            state_next = S_ORG;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD:   if (sts.rd_last) state_next = S_SEL;
      S_SEL:  state_next = S_M1;
      S_M1:   state_next = S_M2;
      S_M2:   state_next = S_M3;
      S_M3:   state_next = S_OUT;
      S_OUT:  if (sts.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Command decode.
  always_comb begin
    cmd          = '0;
    cmd.axis     = axis;
    cmd.wr_en    = accept && req_type == REQ_WRITE;
    cmd.load_pos = accept && req_type == REQ_QUERY;
    cmd.org      = (state == S_ORG);
    cmd.chk      = (state == S_CHK);
    cmd.nmul     = (state == S_NMUL);
    cmd.div      = (state == S_DIV);
    cmd.rd       = (state == S_RD);
    cmd.sel      = (state == S_SEL);
    cmd.m1       = (state == S_M1);
    cmd.m2       = (state == S_M2);
    cmd.m3       = (state == S_M3);
    cmd.load_out = (state == S_OUT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/hmtq_datapath.sv
// Datapath of the height query block: configuration registers, height memory,
// tile check, shared restoring divider, interpolation and output register.
// Depends on hmtq_pkg; driven by hmtq_ctrl through cmd_t and sts_t.
`default_nettype none

module hmtq_datapath #(
  parameter int GRID_POINTS = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hmtq_pkg::cmd_t       cmd,
  output hmtq_pkg::sts_t       sts,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic signed [31:0]   pos_x,
  input  logic signed [31:0]   pos_z,
  input  logic [7:0]           write_col,
  input  logic [7:0]           write_row,
  input  logic signed [23:0]   write_height,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic signed [23:0]   height_out,
  output logic                 off_tile
);
  import hmtq_pkg::*;

  localparam int IW = $clog2(GRID_POINTS);
  localparam int QW = IW + 16;
  localparam int CW = $clog2(QW);
  localparam int NW = 24 + IW;
  localparam int AW = $clog2(GRID_POINTS * GRID_POINTS);
  localparam int DEPTH = GRID_POINTS * GRID_POINTS;

  // Configuration registers.
  logic [15:0]        tile_size;
  logic signed [15:0] tile_col, tile_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_size <= TILE_SIZE_RST;
      tile_col  <= '0;
      tile_row  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TILE_SIZE: tile_size <= cfg_data;
        CFG_TILE_COL:  tile_col  <= cfg_data;
        CFG_TILE_ROW:  tile_row  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Height memory, one write and one read per cycle, registered read data.
  logic signed [23:0] mem [DEPTH];
  logic signed [23:0] rdata;
  logic [AW-1:0]      waddr, raddr;
  logic               wr_ok;

  assign wr_ok = (32'(write_col) < 32'(GRID_POINTS)) && (32'(write_row) < 32'(GRID_POINTS));
  assign waddr = AW'(AW'(write_col) * AW'(GRID_POINTS) + AW'(write_row));

  always_ff @(posedge clk) begin
    if (cmd.wr_en && wr_ok) begin
      mem[waddr] <= write_height;
    end
    rdata <= mem[raddr];
  end

  // Query position and tile origin for the current axis.
  logic signed [31:0] pos_x_r, pos_z_r, pos_sel;
  logic signed [32:0] org_r;
  logic signed [15:0] tile_sel;
  logic signed [41:0] p42, lo42, hi42, t42;
  logic               in_tile;
  logic               off_r;
  logic [23:0]        t_r;
  logic [23:0]        dvs;

  assign pos_sel  = cmd.axis ? pos_z_r : pos_x_r;
  assign tile_sel = cmd.axis ? tile_row : tile_col;
  assign dvs      = {tile_size, 8'd0};
  assign p42      = 42'(pos_sel);
  assign lo42     = 42'(org_r) <<< 8;
  assign hi42     = lo42 + $signed({18'd0, dvs});
  assign t42      = p42 - lo42;
  assign in_tile  = (p42 >= lo42) && (p42 < hi42);

  // Restoring divider: floor((t * (GRID_POINTS - 1)) * 65536 / dvs), one bit a cycle.
  logic [NW-1:0] n_val;
  logic [23:0]   rem_r, rem_next;
  logic [QW-1:0] q_r, q_next;
  logic [24:0]   r2;
  logic          ge;
  logic [CW-1:0] div_cnt;

  assign n_val    = NW'(t_r) * NW'(GRID_POINTS - 1);
  assign r2       = {rem_r, q_r[QW-1]};
  assign ge       = (r2 >= {1'b0, dvs});
  assign rem_next = ge ? 24'(r2 - {1'b0, dvs}) : r2[23:0];
  assign q_next   = {q_r[QW-2:0], ge};

  // Cell indexes and Q.16 fractions of both axes.
  logic [IW-1:0] cx, cz;
  logic [15:0]   fx, fz;

  // Corner reads: h00, h10, h01, h11 in that order.
  logic [2:0]         rd_cnt;
  logic [IW-1:0]      rcol, rrow;
  logic signed [23:0] h00, h10, h01, h11;

  assign rcol  = cx + IW'(rd_cnt[0]);
  assign rrow  = cz + IW'(rd_cnt[1]);
  assign raddr = AW'(AW'(rcol) * AW'(GRID_POINTS) + AW'(rrow));

  // Interpolation operands and accumulator.
  logic signed [23:0] base_r;
  logic [16:0]        wa_r, wb_r;
  logic signed [24:0] da_r, db_r;
  logic signed [42:0] prod_r;
  logic signed [43:0] acc_r, rnd;
  logic [16:0]        fsum;
  logic               lower;
  logic signed [23:0] res;

  assign fsum  = {1'b0, fx} + {1'b0, fz};
  assign lower = (fsum <= ONE_Q16);
  assign rnd   = (acc_r + 44'sd32768) >>> 16;

  // Round and saturate to signed Q.8.
  always_comb begin
    if (rnd > 44'(H_MAX)) begin
      res = H_MAX;
    end else if (rnd < 44'(H_MIN)) begin
      res = H_MIN;
    end else begin
      res = rnd[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pos) begin
      pos_x_r <= pos_x;
      pos_z_r <= pos_z;
    end
    if (cmd.org) begin
      org_r <= 33'(tile_sel * $signed({1'b0, tile_size}));
    end
    if (cmd.chk) begin
      t_r <= t42[23:0];
    end
    // Divider start: the top of the dividend is already below the divisor.
    if (cmd.nmul) begin
      rem_r   <= n_val[NW-1:IW];
      q_r     <= {n_val[IW-1:0], 16'd0};
      div_cnt <= '0;
    end
    if (cmd.div) begin
      rem_r   <= rem_next;
      q_r     <= q_next;
      div_cnt <= div_cnt + CW'(1);
      if (sts.div_last) begin
        if (cmd.axis) begin
          cz <= q_next[QW-1:16];
          fz <= q_next[15:0];
        end else begin
          cx <= q_next[QW-1:16];
          fx <= q_next[15:0];
        end
      end
    end
    // Read data lands in the cycle after its address, so each corner comes from the previous address.
    if (cmd.rd) begin
      rd_cnt <= rd_cnt + 3'd1;
      case (rd_cnt)
        3'd1: h00 <= rdata;
        3'd2: h10 <= rdata;
        3'd3: h01 <= rdata;
        3'd4: h11 <= rdata;
        default: ;
      endcase
    end else begin
      rd_cnt <= '0;
    end
    // Triangle select: lower when fx + fz <= 1.0.
    if (cmd.sel) begin
      if (lower) begin
        base_r <= h00;
        wa_r   <= {1'b0, fx};
        da_r   <= 25'(h10) - 25'(h00);
        wb_r   <= {1'b0, fz};
        db_r   <= 25'(h01) - 25'(h00);
      end else begin
        base_r <= h11;
        wa_r   <= ONE_Q16 - {1'b0, fx};
        da_r   <= 25'(h01) - 25'(h11);
        wb_r   <= ONE_Q16 - {1'b0, fz};
        db_r   <= 25'(h10) - 25'(h11);
      end
    end
    if (cmd.m1) begin
      prod_r <= $signed({1'b0, wa_r}) * da_r;
    end
    if (cmd.m2) begin
      acc_r  <= (44'(base_r) <<< 16) + 44'(prod_r);
      prod_r <= $signed({1'b0, wb_r}) * db_r;
    end
    if (cmd.m3) begin
      acc_r <= acc_r + 44'(prod_r);
    end
    if (cmd.load_out) begin
      height_out <= off_r ? H_MIN : res;
      off_tile   <= off_r;
    end
  end

  // Off-tile flag, cleared at each new query.
  always_ff @(posedge clk) begin
    if (rst) begin
      off_r <= 1'b0;
    end else if (cmd.load_pos) begin
      off_r <= 1'b0;
    end else if (cmd.chk && !in_tile) begin
      off_r <= 1'b1;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign sts.outside  = !in_tile;
  assign sts.div_last = (div_cnt == CW'(QW - 1));
  assign sts.rd_last  = (rd_cnt == 3'd4);
  assign sts.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

FILE: design/heightmap_triangle_height_query.sv
// Top level of the heightmap triangle height query block.
// Depends on hmtq_pkg, hmtq_ctrl and hmtq_datapath.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  req_type, pos_x, pos_z, write_col,
//                                            write_row, write_height
//   out      output     out_valid/out_stall  height_out, off_tile
//   cfg      input      cfg_we               cfg_index, cfg_data
//
// A write item does not leave the idle state, so the block is ready again in the next cycle.
// A query on the tile steps through ORG, CHK, NMUL and DIV once per axis, then RD, SEL,
// M1, M2, M3 and OUT; the divider yields one quotient bit per cycle. An off-tile query
// goes from CHK straight to OUT, on the first axis or after the first axis's division.
// The result sits in an output register, and the next item is taken while it waits;
// a finished query whose result cannot enter that register keeps the input stalled.
// Reset is synchronous; the height memory is not cleared.
`default_nettype none

module heightmap_triangle_height_query #(
  parameter int GRID_POINTS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_z,
  input  logic [7:0]         write_col,
  input  logic [7:0]         write_row,
  input  logic signed [23:0] write_height,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] height_out,
  output logic               off_tile,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import hmtq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  hmtq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  hmtq_datapath #(
    .GRID_POINTS (GRID_POINTS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pos_x        (pos_x),
    .pos_z        (pos_z),
    .write_col    (write_col),
    .write_row    (write_row),
    .write_height (write_height),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .height_out   (height_out),
    .off_tile     (off_tile)
  );

endmodule

`default_nettype wire

FILE: design/hmtq_checker.sv
// Port-level checker for the height query block, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module hmtq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        req_type,
  input logic        out_valid,
  input logic        out_stall,
  input logic [23:0] height_out,
  input logic        off_tile
);

  // A waiting result holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(height_out) && $stable(off_tile))
    else $error("result changed while stalled");

  // Off-tile results carry the most negative height.
  a_off_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && off_tile |-> height_out == 24'h800000)
    else $error("off-tile result has wrong height");

  // A write item leaves the block ready in the next cycle.
  a_write_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && !req_type |=> !in_stall)
    else $error("block busy after a write item");

  // A query item keeps the block busy in the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type |=> in_stall)
    else $error("block ready right after a query item");

endmodule

bind heightmap_triangle_height_query hmtq_checker u_hmtq_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .req_type   (req_type),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .height_out (height_out),
  .off_tile   (off_tile)
);

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for heightmap_triangle_height_query.
// Depends on hmtq_pkg and the block's RTL. It holds its own height grid and interpolation,
// drives grid loads and queries under random idling, and checks every returned height.
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hmtq_pkg::*;

  localparam int GRID = 256;
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASE_ITEMS = 60;

  // One input item as seen at the input handshake.
  typedef struct {
    logic               kind;
    logic signed [31:0] px;
    logic signed [31:0] pz;
    logic [7:0]         col;
    logic [7:0]         row;
    logic signed [23:0] hgt;
  } terrain_req_t;

  // One expected answer.
  typedef struct {
    logic signed [23:0] hgt;
    logic               off;
  } height_answer_t;

  // Predicts the interpolated height of each query and checks the block's answers.
  class terrain_height_predictor;
    int grid [GRID][GRID];
    bit loaded [GRID][GRID];
    int unsigned size_units;
    int col_idx;
    int row_idx;
    height_answer_t pending_heights [$];
    int mismatches;
    int answers_seen;

    function new();
      size_units = TILE_SIZE_RST;
      col_idx = 0;
      row_idx = 0;
      mismatches = 0;
      answers_seen = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [15:0] value);
      case (idx)
        CFG_TILE_SIZE: size_units = value;
        CFG_TILE_COL: col_idx = $signed(value);
        CFG_TILE_ROW: row_idx = $signed(value);
        default: ;
      endcase
    endfunction

    // Finds cell and Q.16 fraction on one axis; returns 0 when off the tile.
    function bit find_cell(longint pos, int tile_idx, output int cell_idx, output longint frac);
      longint d;
      longint org;
      longint n;
      d = longint'(size_units) * 256;
      org = longint'(tile_idx) * d;
      cell_idx = 0;
      frac = 0;
      if (d == 0 || pos < org || pos >= org + d) return 0;
      n = (pos - org) * (GRID - 1);
      cell_idx = int'(n / d);
      frac = ((n % d) * 65536) / d;
      return 1;
    endfunction

    function void note_input(terrain_req_t it);
      height_answer_t ans;
      int cx;
      int cz;
      longint fx;
      longint fz;
      longint h00;
      longint h10;
      longint h01;
      longint h11;
      longint acc;
      longint res;
      bit on_tile;
      if (it.kind == REQ_WRITE) begin
        grid[it.col][it.row] = it.hgt;
        return;
      end
      on_tile = find_cell(longint'(it.px), col_idx, cx, fx);
      if (on_tile) on_tile = find_cell(longint'(it.pz), row_idx, cz, fz);
      if (!on_tile || cx + 1 >= GRID || cz + 1 >= GRID) begin
        ans.hgt = H_MIN;
        ans.off = 1'b1;
      end else begin
        h00 = grid[cx][cz];
        h10 = grid[cx + 1][cz];
        h01 = grid[cx][cz + 1];
        h11 = grid[cx + 1][cz + 1];
        // Lower triangle when the fractions sum to at most one.
        if (fx + fz <= 65536)
          acc = h00 * 65536 + fx * (h10 - h00) + fz * (h01 - h00);
        else
          acc = h11 * 65536 + (65536 - fx) * (h01 - h11) + (65536 - fz) * (h10 - h11);
        res = (acc + 32768) >>> 16;
        if (res > longint'(H_MAX)) res = H_MAX;
        if (res < longint'(H_MIN)) res = H_MIN;
        ans.hgt = res[23:0];
        ans.off = 1'b0;
      end
      pending_heights = {pending_heights, ans};
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_answer(logic signed [23:0] hgt, logic off);
      height_answer_t exp_ans;
      answers_seen++;
      if (pending_heights.size() == 0) begin
        report_mismatch($sformatf("unexpected item height=%0d off=%0b", hgt, off));
        return;
      end
      exp_ans = pending_heights.pop_front();
      if (off !== exp_ans.off)
        report_mismatch($sformatf("off_tile %0b, expected %0b", off, exp_ans.off));
      if (hgt !== exp_ans.hgt)
        report_mismatch($sformatf("height_out %0d, expected %0d", hgt, exp_ans.hgt));
    endtask
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               req_type;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_z;
  logic [7:0]         write_col;
  logic [7:0]         write_row;
  logic signed [23:0] write_height;
  logic               out_valid;
  logic               out_stall;
  logic signed [23:0] height_out;
  logic               off_tile;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;

  terrain_height_predictor pred = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int queries_sent = 0;
  int loads_sent = 0;

  heightmap_triangle_height_query dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .pos_x(pos_x), .pos_z(pos_z),
    .write_col(write_col), .write_row(write_row), .write_height(write_height),
    .out_valid(out_valid), .out_stall(out_stall),
    .height_out(height_out), .off_tile(off_tile),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Output side: random stalls, plus long hold-offs when asked.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watch both handshakes.
  always @(posedge clk) begin
    terrain_req_t seen;
    if (!rst && in_valid && !in_stall) begin
      seen.kind = req_type;
      seen.px = pos_x;
      seen.pz = pos_z;
      seen.col = write_col;
      seen.row = write_row;
      seen.hgt = write_height;
      pred.note_input(seen);
    end
    if (!rst && out_valid && !out_stall) pred.check_answer(height_out, off_tile);
  end

  // Offers one item after a random gap and waits until it is taken.
  task automatic send_item(terrain_req_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= it.kind;
    pos_x <= it.px;
    pos_z <= it.pz;
    write_col <= it.col;
    write_row <= it.row;
    write_height <= it.hgt;
    if (it.kind == REQ_QUERY) queries_sent++;
    else loads_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits until every expected height is back and the block has gone quiet.
  task automatic drain_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pred.pending_heights.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    pred.set_register(idx, value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_height(int c, int r, int h);
    terrain_req_t it;
    it.kind = REQ_WRITE;
    it.px = $urandom();
    it.pz = $urandom();
    it.col = 8'(c);
    it.row = 8'(r);
    it.hgt = 24'(h);
    pred.loaded[c][r] = 1'b1;
    send_item(it);
  endtask

  // Loads any corner of the query's cell that has never been given a height.
  task automatic prepare_corners(longint x, longint z);
    int cx;
    int cz;
    longint fx;
    longint fz;
    if (!pred.find_cell(x, pred.col_idx, cx, fx)) return;
    if (!pred.find_cell(z, pred.row_idx, cz, fz)) return;
    if (cx + 1 >= GRID || cz + 1 >= GRID) return;
    for (int dc = 0; dc < 2; dc++)
      for (int dr = 0; dr < 2; dr++)
        if (!pred.loaded[cx + dc][cz + dr])
          load_height(cx + dc, cz + dr, $signed($urandom()) >>> 8);
  endtask

  task automatic query_at(longint x, longint z);
    terrain_req_t it;
    prepare_corners(x, z);
    it.kind = REQ_QUERY;
    it.px = x[31:0];
    it.pz = z[31:0];
    it.col = 8'($urandom());
    it.row = 8'($urandom());
    it.hgt = 24'($urandom());
    send_item(it);
  endtask

  // Picks one query coordinate: mostly on the tile, some at its edges, some anywhere.
  function automatic longint pick_coord(int tile_idx);
    longint d;
    longint org;
    longint v;
    int pick;
    d = longint'(pred.size_units) * 256;
    org = longint'(tile_idx) * d;
    pick = $urandom_range(99);
    if (pick < 70 && d > 0) v = org + longint'({$urandom(), $urandom()} % d);
    else if (pick < 85) begin
      case ($urandom_range(3))
        0: v = org;
        1: v = org - 1;
        2: v = org + d - 1;
        default: v = org + d;
      endcase
    end else v = longint'($signed($urandom()));
    if (v > 64'sd2147483647 || v < -64'sd2147483648) v = longint'($signed($urandom()));
    return v;
  endfunction

  // Tile settings per phase, the extremes among them.
  logic [15:0] phase_size [7] = '{16'd256, 16'd1, 16'd65535, 16'd100, 16'd37, 16'd0, 16'd3};
  logic [15:0] phase_col  [7] = '{16'd0, 16'd0, 16'd0, 16'hFFFB, 16'd32767, 16'd0, 16'h8000};
  logic [15:0] phase_row  [7] = '{16'd0, 16'hFFFF, 16'd0, 16'd3, 16'h8000, 16'd5, 16'd32767};

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_WRITE;
    pos_x = '0;
    pos_z = '0;
    write_col = '0;
    write_row = '0;
    write_height = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_TILE_SIZE;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extreme heights at both ends of the grid and queries at tile corners.
    // Each query loads the corners of its cell first when they are still empty.
    load_height(0, 0, H_MAX);
    load_height(1, 0, H_MAX);
    load_height(0, 1, H_MAX);
    load_height(1, 1, H_MIN);
    load_height(254, 254, H_MIN);
    load_height(255, 254, H_MAX);
    load_height(254, 255, 0);
    load_height(255, 255, H_MIN);
    query_at(0, 0);
    query_at(128, 64);
    query_at(255, 255);
    query_at(65535, 65535);
    query_at(65280, 65535);
    query_at(-1, 0);
    query_at(0, 65536);
    query_at(64'sh7FFFFFFF, -64'sh80000000);
    query_at(-64'sh80000000, 64'sh7FFFFFFF);
    query_at(100, 200);
    drain_block();

    // Random part, one tile setting per phase.
    for (int p = 0; p < 7; p++) begin
      write_register(CFG_TILE_SIZE, phase_size[p]);
      write_register(CFG_TILE_COL, phase_col[p]);
      write_register(CFG_TILE_ROW, phase_row[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case ((n * 3) / PHASE_ITEMS)
          0: begin send_idle_pct = 22; recv_idle_pct = 50; end
          1: begin send_idle_pct = 50; recv_idle_pct = 22; end
          default: begin send_idle_pct = 0; recv_idle_pct = 0; end
        endcase
        if (n == 20) hold_requests++;
        if (n == 35) drain_block();
        if ($urandom_range(99) < 20)
          load_height($urandom_range(255), $urandom_range(255), $signed($urandom()) >>> 8);
        else
          query_at(pick_coord(pred.col_idx), pick_coord(pred.row_idx));
      end
      drain_block();
    end

    $display("Covered %0d grid loads and %0d queries over 7 tile settings,", loads_sent,
             queries_sent);
    $display("with %0d heights returned under random and long output stalls.",
             pred.answers_seen);
    if (pred.pending_heights.size() != 0)
      pred.report_mismatch($sformatf("%0d heights never returned",
                                     pred.pending_heights.size()));
    if (pred.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hard stop if the block hangs.
  initial begin
    #(12 * 4000000);
    $display("Timeout waiting for the block");
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
